### rtl/mdio_mm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mdio_mm_pkg
// Types and constants shared by the clause 22 MDIO management master.
// ----------------------------------------------------------------------------
package mdio_mm_pkg;

   localparam int BitPosWidth   = 7;
   localparam int PrescaleWidth = 6;
   localparam int HalfWidth     = 7;
   localparam int DataWidth     = 16;
   localparam int FrameBits     = 32;
   localparam int ReadDriveBits = 14;
   localparam int EventBit      = 23;
   localparam int OpRdBit       = 29;
   localparam int OpWrBit       = 28;
   localparam int MaxHalf       = 64;
   localparam logic [HalfWidth-1:0] HalfReset = 7'd14;

   typedef enum logic [1:0] {
      MODE_WRITE = 2'd0,
      MODE_READ  = 2'd1,
      MODE_TICK  = 2'd2
   } mode_type;

   typedef enum logic {
      SEL_FRAME = 1'b0,
      SEL_EVENT = 1'b1
   } sel_type;

   typedef enum logic {
      CSR_MDC_HALF_PERIOD = 1'b0,
      CSR_PREAMBLE_SKIP   = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [HalfWidth-1:0] mdc_half_period;
      logic                 preamble_skip;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic        reg_select;
      logic        mdio_in;
      logic [31:0] write_data;
   } req_item_type;

   // packed so read_data sits in the low bits
   typedef struct packed {
      logic        busy_res;
      logic        event_flag;
      logic        mdio_drive;
      logic        mdio_out;
      logic        mdc;
      logic [31:0] read_data;
   } rsp_item_type;

endpackage : mdio_mm_pkg
`default_nettype wire

### rtl/mdio_mm_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mdio_mm_core
// Frame state, MDC prescaler and bit shifter; computes one result per beat.
// ----------------------------------------------------------------------------
module mdio_mm_core
   import mdio_mm_pkg::*;
#(
   parameter int PREAMBLE_BITS = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         en,
   input  wire req_item_type item,
   input  wire cfg_type      cfg,
   output rsp_item_type      result
);

   logic [31:0]              frame_word_ff, frame_word_in;
   logic                     event_ff, event_in;
   logic                     shifting_ff, shifting_in;
   logic [PrescaleWidth-1:0] prescale_ff, prescale_in;
   logic [BitPosWidth-1:0]   bit_pos_ff, bit_pos_in;
   logic                     clock_level_ff, clock_level_in;
   logic [DataWidth-1:0]     read_shift_ff, read_shift_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_word_ff  <= '0;
         event_ff       <= 1'b0;
         shifting_ff    <= 1'b0;
         prescale_ff    <= '0;
         bit_pos_ff     <= '0;
         clock_level_ff <= 1'b0;
         read_shift_ff  <= '0;
      end else if (en) begin
         frame_word_ff  <= frame_word_in;
         event_ff       <= event_in;
         shifting_ff    <= shifting_in;
         prescale_ff    <= prescale_in;
         bit_pos_ff     <= bit_pos_in;
         clock_level_ff <= clock_level_in;
         read_shift_ff  <= read_shift_in;
      end
   end

   logic [BitPosWidth-1:0] pre_len;
   logic [HalfWidth-1:0]   half;
   logic                   read_frame;

   assign pre_len    = cfg.preamble_skip ? '0 : BitPosWidth'(PREAMBLE_BITS);
   assign read_frame = frame_word_ff[OpRdBit] & ~frame_word_ff[OpWrBit];

   always_comb begin
      if (cfg.mdc_half_period == '0) begin
         half = HalfWidth'(1);
      end else if (cfg.mdc_half_period > HalfWidth'(MaxHalf)) begin
         half = HalfWidth'(MaxHalf);
      end else begin
         half = cfg.mdc_half_period;
      end
   end

   logic [BitPosWidth-1:0] fb;
   logic [BitPosWidth-1:0] bit_pos_inc;
   logic                   read_next;
   logic [BitPosWidth-1:0] fb_next;

   always_comb begin
      frame_word_in    = frame_word_ff;
      event_in         = event_ff;
      shifting_in      = shifting_ff;
      prescale_in      = prescale_ff;
      bit_pos_in       = bit_pos_ff;
      clock_level_in   = clock_level_ff;
      read_shift_in    = read_shift_ff;
      result.read_data = '0;
      fb               = bit_pos_ff - pre_len;
      bit_pos_inc      = bit_pos_ff + BitPosWidth'(1);

      case (mode_type'(item.mode))
         MODE_WRITE: begin
            if (sel_type'(item.reg_select) == SEL_FRAME) begin
               if (!shifting_ff) begin
                  frame_word_in  = item.write_data;
                  shifting_in    = 1'b1;
                  bit_pos_in     = '0;
                  prescale_in    = '0;
                  clock_level_in = 1'b0;
                  read_shift_in  = '0;
               end
            end else if (item.write_data[EventBit]) begin
               event_in = 1'b0;
            end
         end
         MODE_READ: begin
            if (sel_type'(item.reg_select) == SEL_EVENT) begin
               result.read_data           = '0;
               result.read_data[EventBit] = event_ff;
            end else begin
               result.read_data = frame_word_ff;
            end
         end
         MODE_TICK: begin
            if (shifting_ff) begin
               if ({1'b0, prescale_ff} + HalfWidth'(1) < half) begin
                  prescale_in = prescale_ff + PrescaleWidth'(1);
               end else begin
                  prescale_in    = '0;
                  clock_level_in = ~clock_level_ff;
                  if (!clock_level_ff) begin
                     // rising MDC: sample read data
                     if (bit_pos_ff >= pre_len && read_frame
                         && fb >= BitPosWidth'(DataWidth)
                         && fb < BitPosWidth'(FrameBits)) begin
                        read_shift_in = {read_shift_ff[DataWidth-2:0], item.mdio_in};
                     end
                  end else begin
                     bit_pos_in = bit_pos_inc;
                     if (bit_pos_inc >= pre_len + BitPosWidth'(FrameBits)) begin
                        if (read_frame) begin
                           frame_word_in[DataWidth-1:0] = read_shift_ff;
                        end
                        shifting_in    = 1'b0;
                        bit_pos_in     = '0;
                        clock_level_in = 1'b0;
                        event_in       = 1'b1;
                     end
                  end
               end
            end
         end
         default: begin
         end
      endcase

      // pins reflect the state after this beat
      read_next         = frame_word_in[OpRdBit] & ~frame_word_in[OpWrBit];
      fb_next           = bit_pos_in - pre_len;
      result.mdio_drive = 1'b0;
      result.mdio_out   = 1'b0;
      if (shifting_in) begin
         if (bit_pos_in < pre_len) begin
            result.mdio_drive = 1'b1;
            result.mdio_out   = 1'b1;
         end else if (fb_next < BitPosWidth'(FrameBits)
                      && !(read_next && fb_next >= BitPosWidth'(ReadDriveBits))) begin
            result.mdio_drive = 1'b1;
            result.mdio_out   = frame_word_in[~fb_next[4:0]];
         end
      end
      result.mdc        = clock_level_in;
      result.event_flag = event_in;
      result.busy_res   = shifting_in;
   end

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      !shifting_ff |-> (!clock_level_ff && bit_pos_ff == '0))
      else $error("idle with MDC high or nonzero bit position");

   a_done_event: assert property (@(posedge clock) disable iff (reset)
      $fell(shifting_ff) |-> event_ff)
      else $error("frame ended without event");

   a_start_clean: assert property (@(posedge clock) disable iff (reset)
      $rose(shifting_ff) |-> (prescale_ff == '0 && read_shift_ff == '0))
      else $error("frame started with stale prescaler or read data");

endmodule : mdio_mm_core
`default_nettype wire

### rtl/mdio_management_master_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mdio_management_master_top
// Clause 22 MDIO management master: register access and tick stream in,
// register read data and pin levels out.
//
//   channel  dir  handshake        payload
//   req      in   tvalid/tready    tdata: write_data, mdio_in; tuser: mode, reg_select
//   rsp      out  tvalid/tready    tdata: read_data, mdc, mdio_out, mdio_drive,
//                                         event_flag, busy_res
//   csr      in   we               addr: register index, wdata: value
//
// One beat per clock while rsp is not stalled; input register, then result register.
// Synchronous reset returns core state, valid flags and configuration to defaults.
// A stalled rsp holds the result; req keeps accepting while the input stage
// can drain into the result register.
// ----------------------------------------------------------------------------
module mdio_management_master_top
   import mdio_mm_pkg::*;
#(
   parameter int PREAMBLE_BITS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,  // write_data[31:0], mdio_in[32], zero pad
   input  wire logic [2:0]  req_tuser,  // mode[1:0], reg_select[2]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,  // read_data[31:0], mdc, mdio_out, mdio_drive,
                                        // event_flag, busy_res, zero pad
   input  wire logic        csr_we,
   input  wire logic        csr_addr,
   input  wire logic [6:0]  csr_wdata
);

   logic [HalfWidth-1:0] mdc_half_period_ff;
   logic                 preamble_skip_ff;
   cfg_type              cfg;

   always_ff @(posedge clock) begin
      if (reset) begin
         mdc_half_period_ff <= HalfReset;
         preamble_skip_ff   <= 1'b0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_MDC_HALF_PERIOD: mdc_half_period_ff <= csr_wdata;
            CSR_PREAMBLE_SKIP:   preamble_skip_ff   <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   assign cfg.mdc_half_period = mdc_half_period_ff;
   assign cfg.preamble_skip   = preamble_skip_ff;

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff;
   rsp_item_type core_result;
   logic         advance;

   assign advance    = in_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff.mode       <= req_tuser[1:0];
         in_item_ff.reg_select <= req_tuser[2];
         in_item_ff.mdio_in    <= req_tdata[32];
         in_item_ff.write_data <= req_tdata[31:0];
      end
      if (advance) begin
         rsp_item_ff <= core_result;
      end
   end

   mdio_mm_core #(
      .PREAMBLE_BITS(PREAMBLE_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .en     (advance),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (core_result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_item_ff};

endmodule : mdio_management_master_top
`default_nettype wire

### tb/sv/mdio_mm_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mdio_mm_checker
// Watches the req, rsp and csr ports of the MDIO management master. It keeps
// its own copy of the frame register, event bit, MDC prescaler and bit
// counter, and predicts one rsp beat for every accepted req beat. Each rsp
// beat is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module mdio_mm_checker
   import mdio_mm_pkg::*;
#(
   parameter int PREAMBLE_BITS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [39:0] req_tdata,  // write_data[31:0], mdio_in[32], zero pad
   input  wire logic [2:0]  req_tuser,  // mode[1:0], reg_select[2]
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [39:0] rsp_tdata,  // read_data[31:0], mdc, mdio_out, mdio_drive,
                                        // event_flag, busy_res, zero pad
   input  wire logic        csr_we,
   input  wire logic        csr_addr,
   input  wire logic [6:0]  csr_wdata,
   output int               failures,
   output int               outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [HalfWidth-1:0]     half_cfg;
   logic                     skip_cfg;
   logic [FrameBits-1:0]     frame_word;
   logic                     frame_event;
   logic                     shifting;
   logic [PrescaleWidth-1:0] prescale;
   logic [BitPosWidth-1:0]   bit_pos;
   logic                     mdc_level;
   logic [DataWidth-1:0]     read_shift;
   rsp_item_type             expected_rsp_q[$];

   function automatic int preamble_len();
      return skip_cfg ? 0 : PREAMBLE_BITS;
   endfunction

   function automatic int half_ticks();
      if (half_cfg == '0) return 1;
      if (int'(half_cfg) > MaxHalf) return MaxHalf;
      return int'(half_cfg);
   endfunction

   function automatic logic is_read_frame();
      return frame_word[OpRdBit] && !frame_word[OpWrBit];
   endfunction

   function automatic void mdc_tick(logic pin);
      int fb;
      if (!shifting) return;
      if (int'(prescale) + 1 < half_ticks()) begin
         prescale = prescale + 1'b1;
         return;
      end
      prescale  = '0;
      mdc_level = !mdc_level;
      if (mdc_level) begin
         // rising MDC: sample turnaround-free data half of a read
         fb = int'(bit_pos) - preamble_len();
         if (is_read_frame() && fb >= FrameBits - DataWidth && fb < FrameBits)
            read_shift = {read_shift[DataWidth-2:0], pin};
         return;
      end
      bit_pos = bit_pos + 1'b1;
      if (int'(bit_pos) >= preamble_len() + FrameBits) begin
         if (is_read_frame()) frame_word[DataWidth-1:0] = read_shift;
         shifting    = 1'b0;
         bit_pos     = '0;
         mdc_level   = 1'b0;
         frame_event = 1'b1;
      end
   endfunction

   function automatic rsp_item_type predict_mdio_beat(logic [1:0] mode, logic sel,
                                                      logic [31:0] wd, logic pin);
      rsp_item_type r;
      int fb;
      r = '0;
      case (mode)
         MODE_WRITE: begin
            if (sel == SEL_FRAME) begin
               if (!shifting) begin
                  frame_word = wd;
                  shifting   = 1'b1;
                  bit_pos    = '0;
                  prescale   = '0;
                  mdc_level  = 1'b0;
                  read_shift = '0;
               end
            end else if (wd[EventBit]) begin
               frame_event = 1'b0;
            end
         end
         MODE_READ: begin
            r.read_data = (sel == SEL_EVENT) ? (32'(frame_event) << EventBit) : frame_word;
         end
         MODE_TICK: begin
            mdc_tick(pin);
         end
         default: ;
      endcase
      r.mdc        = mdc_level;
      r.event_flag = frame_event;
      r.busy_res   = shifting;
      fb = int'(bit_pos) - preamble_len();
      if (shifting) begin
         if (fb < 0) begin
            r.mdio_drive = 1'b1;
            r.mdio_out   = 1'b1;
         end else if (fb < FrameBits && !(is_read_frame() && fb >= ReadDriveBits)) begin
            r.mdio_drive = 1'b1;
            r.mdio_out   = frame_word[FrameBits-1-fb];
         end
      end
      return r;
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         failures++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_item_type got;
      rsp_item_type want;
      if (reset) begin
         half_cfg    = HalfReset;
         skip_cfg    = 1'b0;
         frame_word  = '0;
         frame_event = 1'b0;
         shifting    = 1'b0;
         prescale    = '0;
         bit_pos     = '0;
         mdc_level   = 1'b0;
         read_shift  = '0;
         expected_rsp_q.delete();
      end else begin
         if (csr_we) begin
            if (csr_addr == CSR_MDC_HALF_PERIOD) half_cfg = csr_wdata;
            else skip_cfg = csr_wdata[0];
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_item_type'(rsp_tdata[$bits(rsp_item_type)-1:0]);
            if (expected_rsp_q.size() == 0) begin
               failures++;
               $display("%0t: rsp beat with none pending, expected nothing, actual %h",
                        $time, got);
            end else begin
               want = expected_rsp_q.pop_front();
               check_field("read_data", want.read_data, got.read_data);
               check_field("mdc", want.mdc, got.mdc);
               check_field("mdio_out", want.mdio_out, got.mdio_out);
               check_field("mdio_drive", want.mdio_drive, got.mdio_drive);
               check_field("event_flag", want.event_flag, got.event_flag);
               check_field("busy_res", want.busy_res, got.busy_res);
            end
         end
         if (req_tvalid && req_tready)
            expected_rsp_q.push_back(predict_mdio_beat(req_tuser[1:0], req_tuser[2],
                                                       req_tdata[31:0], req_tdata[32]));
      end
      outstanding = expected_rsp_q.size();
   end

endmodule : mdio_mm_checker
`default_nettype wire

### tb/sv/tb_mdio_management_master_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_mdio_management_master_top
// Drives register accesses and clock ticks into the MDIO management master:
// a short directed run at reset settings, then phases of fixed, then random,
// MDC speed and preamble setting, each carrying read and write frames with
// random content, random MDIO input and stray accesses mixed in. Both
// channels stall at random. The checker predicts and compares every beat.
// ----------------------------------------------------------------------------
module tb_mdio_management_master_top;
   timeunit 1ns;
   timeprecision 1ps;
   import mdio_mm_pkg::*;

   localparam int         PreambleBits   = 32;
   localparam logic [1:0] ModeUnused     = 2'd3;
   localparam int         TotalBeats     = 1650;
   localparam int         LongFrameTicks = 400;
   localparam int         CycleLimit     = 200000;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;  // write_data[31:0], mdio_in[32], zero pad
   logic [2:0]  req_tuser  = '0;  // mode[1:0], reg_select[2]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // read_data[31:0], mdc, mdio_out, mdio_drive,
                                  // event_flag, busy_res, zero pad
   logic        csr_we     = 1'b0;
   logic        csr_addr   = 1'b0;
   logic [6:0]  csr_wdata  = '0;
   int          failures;
   int          outstanding;
   int          beats      = 0;
   int          cycles     = 0;
   logic        steady;

   assign steady = beats >= 700 && beats < 1000;

   mdio_management_master_top #(.PREAMBLE_BITS(PreambleBits)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   mdio_mm_checker #(.PREAMBLE_BITS(PreambleBits)) checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .failures    (failures),
      .outstanding (outstanding)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CycleLimit) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 35);
   end

   // called at a falling edge; returns at the falling edge after the beat
   task automatic send_beat(logic [1:0] mode, logic sel, logic [31:0] wd, logic pin);
      while (!steady && $urandom_range(99) < 35) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, pin, wd};
      req_tuser  <= {sel, mode};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      beats++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_settings(logic [6:0] half, logic skip);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_MDC_HALF_PERIOD;
      csr_wdata <= half;
      @(negedge clock);
      csr_addr  <= CSR_PREAMBLE_SKIP;
      csr_wdata <= {6'd0, skip};
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic send_stray();
      case ($urandom_range(4))
         0: send_beat(MODE_READ, SEL_FRAME, $urandom, $urandom_range(1));
         1: send_beat(MODE_READ, SEL_EVENT, $urandom, $urandom_range(1));
         2: send_beat(MODE_WRITE, SEL_FRAME, $urandom, $urandom_range(1));
         3: send_beat(MODE_WRITE, SEL_EVENT, $urandom, $urandom_range(1));
         default: send_beat(ModeUnused, $urandom_range(1), $urandom, $urandom_range(1));
      endcase
   endtask

   task automatic run_frame(int half_eff, logic skip);
      logic [31:0] frame;
      int pick;
      int need;
      int ticks;
      frame = $urandom;
      pick  = $urandom_range(9);
      if (pick < 4) frame[OpRdBit:OpWrBit] = 2'b10;
      else if (pick < 7) frame[OpRdBit:OpWrBit] = 2'b01;
      send_beat(MODE_WRITE, SEL_FRAME, frame, $urandom_range(1));
      need  = ((skip ? 0 : PreambleBits) + FrameBits) * 2 * half_eff;
      ticks = (need <= LongFrameTicks) ? need + $urandom_range(3) : $urandom_range(100, 300);
      if ($urandom_range(9) == 0) ticks = $urandom_range(ticks);
      repeat (ticks) begin
         if ($urandom_range(99) < 8) send_stray();
         send_beat(MODE_TICK, $urandom_range(1), $urandom, $urandom_range(1));
      end
      send_beat(MODE_READ, SEL_EVENT, $urandom, $urandom_range(1));
      send_beat(MODE_READ, SEL_FRAME, $urandom, $urandom_range(1));
      if ($urandom_range(1))
         send_beat(MODE_WRITE, SEL_EVENT, $urandom | (32'd1 << EventBit), $urandom_range(1));
   endtask

   initial begin
      logic [6:0] half;
      logic       skip;
      int         half_eff;
      int         phase;
      int         pick;
      phase = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: idle reads, unused mode, event write and clear, busy write
      send_beat(MODE_READ, SEL_FRAME, '0, 1'b0);
      send_beat(MODE_READ, SEL_EVENT, '1, 1'b1);
      send_beat(ModeUnused, SEL_EVENT, '1, 1'b1);
      send_beat(MODE_WRITE, SEL_EVENT, 32'hff7f_ffff, 1'b0);
      send_beat(MODE_WRITE, SEL_EVENT, 32'h0080_0000, 1'b1);
      send_beat(MODE_TICK, SEL_FRAME, '0, 1'b1);
      send_beat(MODE_WRITE, SEL_FRAME, '1, 1'b0);
      send_beat(MODE_WRITE, SEL_FRAME, '0, 1'b1);
      send_beat(MODE_READ, SEL_FRAME, '0, 1'b0);
      repeat (15) send_beat(MODE_TICK, SEL_FRAME, $urandom, $urandom_range(1));

      while (beats < TotalBeats) begin
         drain();
         case (phase)
            0: begin half = 7'd0;   skip = 1'b1; end
            1: begin half = 7'd127; skip = 1'b0; end
            2: begin half = 7'd1;   skip = 1'b0; end
            3: begin half = 7'd64;  skip = 1'b1; end
            default: begin
               pick = $urandom_range(19);
               if (pick < 8) half = 7'd1;
               else if (pick < 11) half = 7'd0;
               else if (pick < 14) half = 7'd2;
               else if (pick < 16) half = 7'($urandom_range(3, 6));
               else if (pick == 16) half = 7'd64;
               else if (pick == 17) half = 7'd127;
               else half = 7'($urandom_range(127));
               skip = $urandom_range(1);
            end
         endcase
         phase++;
         half_eff = (half == 0) ? 1 : (int'(half) > MaxHalf) ? MaxHalf : int'(half);
         write_settings(half, skip);
         repeat ((half_eff > 8) ? 1 : $urandom_range(1, 3))
            if (beats < TotalBeats) run_frame(half_eff, skip);
      end

      drain();
      repeat (8) @(negedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule : tb_mdio_management_master_top
`default_nettype wire

### files.f
rtl/mdio_mm_pkg.sv
rtl/mdio_mm_core.sv
rtl/mdio_management_master_top.sv
tb/sv/mdio_mm_checker.sv
tb/sv/tb_mdio_management_master_top.sv
